/* hw/rtl/c3zp_pkg.sv */
// ---------------------------------------------------------------------------
// c3zp_pkg: shared types and constants of the 3x3 zero-padded convolution
// Pixel and column types, the cell control bundle, register map and defaults.
// ---------------------------------------------------------------------------
package c3zp_pkg;

    localparam int PIX_W         = 8;
    localparam int OUT_W         = 20;
    localparam int COEF_REG_W    = 24;
    localparam int WID_W         = 11;
    localparam int HGT_W         = 13;
    localparam int ROW_W         = HGT_W + 1;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 8;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_COEFF_TOP = 3'd0;
    localparam logic [2:0] REG_COEFF_MID = 3'd1;
    localparam logic [2:0] REG_COEFF_BOT = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;

    typedef logic [PIX_W-1:0] t_pix;

    // one window column: [0] row above, [1] center row, [2] row below
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic load;     // window advances this cycle
        logic restart;  // load the fill column instead of the neighbor
        logic snap;     // capture the neighbor column for a result
        logic prod_en;  // product stage advances
        logic sum_en;   // column sum stage advances
    } t_cell_ctl;

endpackage

/* hw/rtl/c3zp_cell.sv */
// ---------------------------------------------------------------------------
// c3zp_cell: one column of the 3x3 window
// Holds a window column, takes its right neighbor's column on each step,
// and weighs a captured column by its three coefficients over two stages.
// ---------------------------------------------------------------------------
module c3zp_cell
    import c3zp_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  t_col                          i_feed,
    input  t_col                          i_fill,
    input  logic [2:0][COEF_BITS-1:0]     i_coef,
    output t_col                          o_col,
    output logic signed [COEF_BITS+10:0]  o_sum
);

    localparam int PW = COEF_BITS + 9;

    t_col                   r_col;
    t_col                   r_snap;
    logic signed [PW-1:0]   r_prod [3];
    logic signed [PW+1:0]   r_sum;

    // window column: shift in from the right or restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.load) begin
            r_col <= i_ctl.restart ? i_fill : i_feed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.snap) begin
            r_snap <= i_feed;
        end
        if (i_ctl.prod_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed({1'b0, r_snap[k]}) * $signed(i_coef[k]);
            end
        end
        if (i_ctl.sum_en) begin
            r_sum <= (PW+2)'(r_prod[0]) + (PW+2)'(r_prod[1]) + (PW+2)'(r_prod[2]);
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

/* hw/rtl/c3zp_linebuf.sv */
// ---------------------------------------------------------------------------
// c3zp_linebuf: the two line stores
// Rows one and two above the current one, read and written per column,
// with a forward path for a read and a write of the same column together.
// ---------------------------------------------------------------------------
module c3zp_linebuf
    import c3zp_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_pix          o_one,
    output t_pix          o_two,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pix          i_wr_one,
    input  t_pix          i_wr_two
);

    t_pix r_mem_one [DEPTH];
    t_pix r_mem_two [DEPTH];
    t_pix r_rd_one;
    t_pix r_rd_two;
    t_pix r_fwd_one;
    t_pix r_fwd_two;
    logic r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_one[i_wr_addr] <= i_wr_one;
            r_mem_two[i_wr_addr] <= i_wr_two;
        end
        if (i_rd_en) begin
            r_rd_one  <= r_mem_one[i_rd_addr];
            r_rd_two  <= r_mem_two[i_rd_addr];
            r_fwd_one <= i_wr_one;
            r_fwd_two <= i_wr_two;
        end
    end

    // forward the data written in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_one = r_fwd ? r_fwd_one : r_rd_one;
    assign o_two = r_fwd ? r_fwd_two : r_rd_two;

endmodule

/* hw/rtl/conv3x3_zero_padded.sv */
// ---------------------------------------------------------------------------
// conv3x3_zero_padded: streaming 3x3 correlation with zero padding
// Line stores, a chain of three window cells and a saturating sum.
// ---------------------------------------------------------------------------
// Usage:
//   Send pixels in raster order on the s_axis channel, one beat each, then
//   image_width+1 flush beats (tuser set) to drain the frame. Every pixel
//   gives one result beat on m_axis; the last result of a frame has tlast.
//   A result for a pixel leaves after the item image_width+1 places later in
//   the stream (the one that completes its lower neighbors).
//   Throughput: one beat per clock on both sides while the receiver is ready.
//   An input beat that completes a result passes the store read, window step,
//   products, column sums and the saturating sum into the output register.
//   Program coefficients and frame size over APB while no frame is moving.
//   Reset clears the window, the position counters, the pipeline valids and
//   the registers to their defaults (width 1024, height 1, coefficients 0).
//   The line stores are not cleared; rows above the image never read them.
//   When the receiver stalls, finished results fill the pipeline stages and
//   the output register; s_axis_tready drops only once they are all full.
// ---------------------------------------------------------------------------
module conv3x3_zero_padded
    import c3zp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pixel stream in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]          s_axis_tuser,   // [0] flush
    // result stream out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [19:0] filtered, [23:20] zero
    output logic                m_axis_tlast,   // frame_end
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CW + 1 > WID_W) ? CW + 1 : WID_W;
    localparam int PW  = COEF_BITS + 9;
    localparam int SW  = PW + 4;
    localparam int SX  = (SW > OUT_W + 1) ? SW : OUT_W + 1;
    localparam logic signed [SX-1:0] SAT_HI = SX'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SX-1:0] SAT_LO = SX'(-(1 << (OUT_W - 1)));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_REG_W-1:0] r_coef_top;
    logic [COEF_REG_W-1:0] r_coef_mid;
    logic [COEF_REG_W-1:0] r_coef_bot;
    logic [WID_W-1:0]      r_width;
    logic [HGT_W-1:0]      r_height;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
            r_width    <= WID_W'(1024);
            r_height   <= HGT_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_COEFF_TOP: r_coef_top <= pwdata[COEF_REG_W-1:0];
                REG_COEFF_MID: r_coef_mid <= pwdata[COEF_REG_W-1:0];
                REG_COEFF_BOT: r_coef_bot <= pwdata[COEF_REG_W-1:0];
                REG_WIDTH:     r_width    <= pwdata[WID_W-1:0];
                REG_HEIGHT:    r_height   <= pwdata[HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_COEFF_TOP: prdata = APB_DW'(r_coef_top);
            REG_COEFF_MID: prdata = APB_DW'(r_coef_mid);
            REG_COEFF_BOT: prdata = APB_DW'(r_coef_bot);
            REG_WIDTH:     prdata = APB_DW'(r_width);
            REG_HEIGHT:    prdata = APB_DW'(r_height);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake chain: each stage advances when its successor has room
    // ------------------------------------------------------------------
    logic r_v1, r_vs, r_vp, r_vc, r_vo;
    logic w_rdy_o, w_rdy_c, w_rdy_p, w_rdy_s, w_fire, w_acc;

    assign w_rdy_o       = !r_vo || m_axis_tready;
    assign w_rdy_c       = !r_vc || w_rdy_o;
    assign w_rdy_p       = !r_vp || w_rdy_c;
    assign w_rdy_s       = !r_vs || w_rdy_p;
    assign w_fire        = r_v1 && w_rdy_s;
    assign s_axis_tready = !r_v1 || w_fire;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Position tracking at the input
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [WW-1:0]    w_w_eff;
    logic [ROW_W-1:0] w_h_eff;
    logic [WW-1:0]    w_col_cur;
    logic [ROW_W-1:0] w_row_cur;
    logic [WW-1:0]    w_col_inc;
    logic [WW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic             w_close;
    logic             w_c0;
    logic             w_emit;
    t_pix             w_px;

    always_comb begin
        w_w_eff = WW'(r_width);
        if (r_width == '0) begin
            w_w_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_w_eff = WW'(MAX_WIDTH);
        end
        w_h_eff = (r_height == '0) ? ROW_W'(1) : ROW_W'(r_height);

        // wrap a column left beyond a shrunk width first
        w_col_cur = WW'(r_col);
        w_row_cur = r_row;
        if (w_col_cur >= w_w_eff) begin
            w_col_cur = '0;
            w_row_cur = r_row + ROW_W'(1);
        end

        w_close = w_row_cur > w_h_eff;
        w_c0    = (w_col_cur == '0);
        // a row start finishes the last pixel two rows up; any other column
        // finishes the pixel above-left of it
        w_emit  = w_close
               || (w_c0 && w_row_cur >= ROW_W'(2))
               || (!w_c0 && w_row_cur >= ROW_W'(1));
        w_px    = (w_row_cur < w_h_eff && !s_axis_tuser[0]) ? s_axis_tdata : '0;

        w_col_inc = w_col_cur + WW'(1);
        n_col     = w_col_inc;
        n_row     = w_row_cur;
        if (w_col_inc >= w_w_eff) begin
            n_col = '0;
            n_row = w_row_cur + ROW_W'(1);
        end
        if (w_close) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            r_col <= n_col[CW-1:0];
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item waits for its line store read
    // ------------------------------------------------------------------
    logic [CW-1:0] r1_addr;
    t_pix          r1_px;
    logic          r1_close;
    logic          r1_restart;
    logic          r1_emit;
    logic          r1_top_ok;
    logic          r1_mid_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_addr    <= w_col_cur[CW-1:0];
            r1_px      <= w_px;
            r1_close   <= w_close;
            r1_restart <= w_c0 || w_close;
            r1_emit    <= w_emit;
            r1_top_ok  <= w_row_cur >= ROW_W'(2);
            r1_mid_ok  <= w_row_cur >= ROW_W'(1);
        end
    end

    t_pix w_one;
    t_pix w_two;

    c3zp_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_col_cur[CW-1:0]),
        .o_one     (w_one),
        .o_two     (w_two),
        .i_wr_en   (w_fire && !r1_close),
        .i_wr_addr (r1_addr),
        .i_wr_one  (r1_px),
        .i_wr_two  (w_one)
    );

    // ------------------------------------------------------------------
    // Window cells: cell 0 is the left column, cell 2 the right
    // ------------------------------------------------------------------
    t_col      w_newcol;
    t_col      w_col  [3];
    t_col      w_feed [3];
    t_col      w_fill [3];
    t_cell_ctl w_ctl;
    logic signed [PW+1:0] w_csum [3];

    logic [3*COEF_BITS+COEF_REG_W-1:0] w_ext_top;
    logic [3*COEF_BITS+COEF_REG_W-1:0] w_ext_mid;
    logic [3*COEF_BITS+COEF_REG_W-1:0] w_ext_bot;

    assign w_ext_top = {{(3*COEF_BITS){1'b0}}, r_coef_top};
    assign w_ext_mid = {{(3*COEF_BITS){1'b0}}, r_coef_mid};
    assign w_ext_bot = {{(3*COEF_BITS){1'b0}}, r_coef_bot};

    assign w_newcol[0] = r1_top_ok ? w_two : '0;
    assign w_newcol[1] = r1_mid_ok ? w_one : '0;
    assign w_newcol[2] = r1_px;

    // on a row start the result view shifts in a zero column
    assign w_feed[0] = w_col[1];
    assign w_feed[1] = w_col[2];
    assign w_feed[2] = r1_restart ? '0 : w_newcol;
    assign w_fill[0] = '0;
    assign w_fill[1] = '0;
    assign w_fill[2] = r1_close ? '0 : w_newcol;

    assign w_ctl.load    = w_fire;
    assign w_ctl.restart = r1_restart;
    assign w_ctl.snap    = w_fire && r1_emit;
    assign w_ctl.prod_en = w_rdy_p;
    assign w_ctl.sum_en  = w_rdy_c;

    for (genvar j = 0; j < 3; j++) begin : g_cell
        logic [2:0][COEF_BITS-1:0] w_coef;

        assign w_coef[0] = w_ext_top[j*COEF_BITS +: COEF_BITS];
        assign w_coef[1] = w_ext_mid[j*COEF_BITS +: COEF_BITS];
        assign w_coef[2] = w_ext_bot[j*COEF_BITS +: COEF_BITS];

        c3zp_cell #(
            .COEF_BITS (COEF_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_feed  (w_feed[j]),
            .i_fill  (w_fill[j]),
            .i_coef  (w_coef),
            .o_col   (w_col[j]),
            .o_sum   (w_csum[j])
        );
    end

    // ------------------------------------------------------------------
    // Result valids and frame end marks alongside the cell stages
    // ------------------------------------------------------------------
    logic r_s_end, r_p_end, r_c_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
            r_vp <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_s) begin
                r_vs <= w_fire && r1_emit;
            end
            if (w_rdy_p) begin
                r_vp <= r_vs;
            end
            if (w_rdy_c) begin
                r_vc <= r_vp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s) begin
            r_s_end <= r1_close;
        end
        if (w_rdy_p) begin
            r_p_end <= r_s_end;
        end
        if (w_rdy_c) begin
            r_c_end <= r_p_end;
        end
    end

    // ------------------------------------------------------------------
    // Final sum, saturate to the 20-bit range, output register
    // ------------------------------------------------------------------
    logic signed [SW-1:0]    w_total;
    logic signed [SX-1:0]    w_total_x;
    logic signed [OUT_W-1:0] w_sat;
    logic [OUT_W-1:0]        r_out;
    logic                    r_out_end;

    always_comb begin
        w_total   = SW'(w_csum[0]) + SW'(w_csum[1]) + SW'(w_csum[2]);
        w_total_x = SX'(w_total);
        if (w_total_x > SAT_HI) begin
            w_sat = OUT_W'(SAT_HI);
        end else if (w_total_x < SAT_LO) begin
            w_sat = OUT_W'(SAT_LO);
        end else begin
            w_sat = w_total_x[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_rdy_o) begin
            r_vo <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o) begin
            r_out     <= w_sat;
            r_out_end <= r_c_end;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {4'b0000, r_out};
    assign m_axis_tlast  = r_out_end;

endmodule

/* hw/rtl/c3zp_checker.sv */
// ---------------------------------------------------------------------------
// c3zp_checker: port-level checks of the convolution block
// Watches the stream ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module c3zp_checker
    import c3zp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // with the output register empty the whole pipeline has room
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    // hold a stalled result beat
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // fill bits above the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:OUT_W] == '0)
        else $error("nonzero fill bits in result");

endmodule

bind conv3x3_zero_padded c3zp_checker u_c3zp_checker (.*);
